>>> design/slot_allocator_with_key_lookup_macros.svh
// assertion helpers
`ifndef SLOT_ALLOCATOR_WITH_KEY_LOOKUP_MACROS_SVH
`define SLOT_ALLOCATOR_WITH_KEY_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
`define SAKL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define SAKL_NEVER(lbl, clk, rst_n, expr) \
	`SAKL_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define SAKL_ASSERT(lbl, clk, rst_n, prop)
`define SAKL_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> design/sakl_pkg.sv
package sakl_pkg;

	localparam int NUM_SLOTS   = 32;
	localparam int MAX_RESULTS = 32;
	localparam int KEY_W       = 64;
	localparam int SLOT_ID_W   = 5;
	localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

	typedef enum logic [1:0] {
		KIND_ACQUIRE = 2'd0,
		KIND_LOOKUP  = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_LIST    = 2'd3
	} kind_t;

	typedef struct packed {
		logic load_req;
		logic load_vec;
		logic emit;
	} sakl_cmd_t;

	typedef struct packed {
		logic can_emit;
		logic last;
	} sakl_sts_t;

	// index of a one-hot (or zero) vector
	function automatic logic [IDX_W-1:0] onehot_index(input logic [NUM_SLOTS-1:0] oh);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (oh[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> design/sakl_ctrl.sv
module sakl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sakl_pkg::sakl_sts_t sts,
	output sakl_pkg::sakl_cmd_t cmd
);
	import sakl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RES
	} state_t;

	state_t state_q;
	logic   accept;
	logic   emit;

	assign emit     = (state_q == ST_RES) && sts.can_emit;
	assign in_ready = (state_q == ST_IDLE) || (emit && sts.last);
	assign accept   = in_valid && in_ready;

	assign cmd.load_req = accept;
	assign cmd.load_vec = (state_q == ST_CMP);
	assign cmd.emit     = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (emit && sts.last) begin
						state_q <= accept ? ST_CMP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/sakl_dp.sv
module sakl_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sakl_pkg::sakl_cmd_t            cmd,
	output sakl_pkg::sakl_sts_t            sts,
	input  logic [1:0]                     kind,
	input  logic [sakl_pkg::KEY_W-1:0]     owner_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [sakl_pkg::SLOT_ID_W-1:0] slot_id,
	output logic                           last
);
	import sakl_pkg::*;

	logic [NUM_SLOTS-1:0]           valid_q;
	logic [KEY_W-1:0]               owner_q [NUM_SLOTS];
	kind_t                          kind_q;
	logic [KEY_W-1:0]               key_q;
	logic [NUM_SLOTS-1:0]           vec_s1;
	logic [CNT_W-1:0]               cnt_q;
	logic                           out_valid_q;
	logic                           found_q;
	logic [SLOT_ID_W-1:0]           slot_id_q;
	logic                           last_q;

	logic [NUM_SLOTS-1:0]           eq;
	logic [NUM_SLOTS-1:0]           vec_d;
	logic [NUM_SLOTS-1:0]           lsb;
	logic [NUM_SLOTS-1:0]           rest;
	logic                           any;
	logic [IDX_W-1:0]               idx;
	logic [IDX_W+SLOT_ID_W-1:0]     idx_wide;
	logic                           key_zero;
	logic                           last_d;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			eq[i] = valid_q[i] && (owner_q[i] == key_q);
		end
	end

	assign key_zero = (key_q == '0);

	always_comb begin
		unique case (kind_q)
			KIND_ACQUIRE: vec_d = key_zero ? '0 : ~valid_q;
			KIND_LOOKUP:  vec_d = eq;
			KIND_RELEASE: vec_d = key_zero ? '0 : eq;
			KIND_LIST:    vec_d = valid_q;
			default:      vec_d = '0;
		endcase
	end

	assign lsb      = vec_s1 & (~vec_s1 + NUM_SLOTS'(1));
	assign rest     = vec_s1 & ~lsb;
	assign any      = |vec_s1;
	assign idx      = onehot_index(lsb);
	assign idx_wide = {{SLOT_ID_W{1'b0}}, idx};
	assign last_d   = (kind_q != KIND_LIST) || (rest == '0) ||
		(cnt_q == CNT_W'(MAX_RESULTS - 1));

	assign sts.can_emit = !out_valid_q || out_ready;
	assign sts.last     = last_d;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= kind_t'(kind);
			key_q  <= owner_key;
		end
		if (cmd.load_vec) begin
			vec_s1 <= vec_d;
		end else if (cmd.emit) begin
			vec_s1 <= rest;
		end
		if (cmd.load_vec) begin
			cnt_q <= '0;
		end else if (cmd.emit) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.emit) begin
			found_q   <= any;
			slot_id_q <= any ? idx_wide[SLOT_ID_W-1:0] : '0;
			last_q    <= last_d;
		end
		if (cmd.emit && any && kind_q == KIND_ACQUIRE) begin
			owner_q[idx] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit && any) begin
				if (kind_q == KIND_ACQUIRE) valid_q[idx] <= 1'b1;
				else if (kind_q == KIND_RELEASE) valid_q[idx] <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign slot_id   = slot_id_q;
	assign last      = last_q;

endmodule

>>> design/slot_allocator_with_key_lookup.sv
// Slot allocator with key lookup.
// Input channel (in_valid/in_ready) takes one request: kind and owner_key.
//   acquire claims the lowest free slot, lookup finds the lowest matching
//   valid slot, release frees it, list reports every valid slot in order.
// Output channel (out_valid/out_ready) returns results: found, slot_id and
//   last, which marks the final result of a request.
// Steps: the request is registered on accept, the next cycle compares the
//   key against all slots in parallel and registers the hit vector, and then
//   the result state encodes the lowest hit and loads the output register
//   once that register is empty or being read. A new request can be accepted
//   in the same cycle as the last result of the previous one is loaded. A
//   list produces one result per cycle after the compare while the receiver
//   keeps up, one per valid slot (at most 32).
// The output register frees the input side: a new request is taken while
//   the previous result still waits. When the receiver stalls, the result
//   holds and the block pauses before loading the next one.
// Reset clears all valid marks; the table is ready in the first cycle.
module slot_allocator_with_key_lookup (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     kind,
	input  logic [sakl_pkg::KEY_W-1:0]     owner_key,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [sakl_pkg::SLOT_ID_W-1:0] slot_id,
	output logic                           last
);
	import sakl_pkg::*;

	`include "slot_allocator_with_key_lookup_macros.svh"

	sakl_cmd_t cmd;
	sakl_sts_t sts;

	sakl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sakl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.owner_key (owner_key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.slot_id   (slot_id),
		.last      (last)
	);

	`SAKL_ASSERT(a_no_back_to_back_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`SAKL_ASSERT(a_not_last_is_found, clk, arst_n, out_valid && !last |-> found)
	`SAKL_ASSERT(a_miss_zero_id, clk, arst_n, out_valid && !found |-> slot_id == '0)
	`SAKL_NEVER(a_load_and_emit, clk, arst_n, cmd.load_vec && cmd.emit)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import sakl_pkg::*;

	localparam int POOL_SIZE  = 16;
	localparam int HOLD_AT    = 40;
	localparam int HOLD_LEN   = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		kind_t             op;
		logic [KEY_W-1:0]  key;
	} request_t;

	typedef struct packed {
		logic                 found;
		logic [SLOT_ID_W-1:0] slot;
		logic                 last;
	} slot_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	kind_t                kind = KIND_ACQUIRE;
	logic [KEY_W-1:0]     owner_key = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 found;
	logic [SLOT_ID_W-1:0] slot_id;
	logic                 last;

	request_t     pending_requests[$];
	slot_result_t awaited_results[$];
	request_t     next_request;
	slot_result_t want;

	logic             shadow_used[NUM_SLOTS];
	logic [KEY_W-1:0] shadow_key[NUM_SLOTS];
	logic [KEY_W-1:0] key_pool[POOL_SIZE];

	int requests_taken = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int op_count[4] = '{0, 0, 0, 0};
	int full_rejects = 0;
	int longest_list = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int send_idle_pct;
	int recv_stall_pct;

	assign send_idle_pct  = (requests_taken < 75) ? 34 : (requests_taken < 150) ? 52 : 0;
	assign recv_stall_pct = (requests_taken < 75) ? 52 : (requests_taken < 150) ? 34 : 0;

	slot_allocator_with_key_lookup DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.owner_key (owner_key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.slot_id   (slot_id),
		.last      (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic slot_result_t make_result(logic hit, int slot, logic fin);
		slot_result_t r;
		r.found = hit;
		r.slot  = hit ? SLOT_ID_W'(slot) : '0;
		r.last  = fin;
		return r;
	endfunction

	// shadow of the slot table, updated per accepted request
	task automatic run_table_op(input kind_t op, input logic [KEY_W-1:0] key);
		int hit;
		int n;
		hit = -1;
		n = 0;
		op_count[op]++;
		case (op)
			KIND_ACQUIRE: begin
				if (key != '0) begin
					for (int i = 0; i < NUM_SLOTS && hit < 0; i++) begin
						if (!shadow_used[i]) begin
							hit = i;
						end
					end
					if (hit >= 0) begin
						shadow_used[hit] = 1'b1;
						shadow_key[hit] = key;
					end else begin
						full_rejects++;
					end
				end
				awaited_results = {awaited_results, make_result(hit >= 0, hit, 1'b1)};
			end
			KIND_LOOKUP, KIND_RELEASE: begin
				if (!(op == KIND_RELEASE && key == '0)) begin
					for (int i = 0; i < NUM_SLOTS && hit < 0; i++) begin
						if (shadow_used[i] && shadow_key[i] == key) begin
							hit = i;
						end
					end
				end
				if (hit >= 0 && op == KIND_RELEASE) begin
					shadow_used[hit] = 1'b0;
				end
				awaited_results = {awaited_results, make_result(hit >= 0, hit, 1'b1)};
			end
			default: begin
				for (int i = 0; i < NUM_SLOTS && n < MAX_RESULTS; i++) begin
					if (shadow_used[i]) begin
						awaited_results = {awaited_results, make_result(1'b1, i, 1'b0)};
						n++;
					end
				end
				if (n == 0) begin
					awaited_results = {awaited_results, make_result(1'b0, 0, 1'b1)};
				end else begin
					awaited_results[$].last = 1'b1;
				end
				if (n > longest_list) begin
					longest_list = n;
				end
			end
		endcase
	endtask

	function automatic logic [KEY_W-1:0] pick_key(kind_t op);
		int roll;
		roll = $urandom_range(99);
		if (op != KIND_LIST && roll < 5) begin
			return '0;
		end
		if (op == KIND_LIST || roll < ((op == KIND_ACQUIRE) ? 20 : 15)) begin
			return {$urandom, $urandom};
		end
		return key_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	task automatic add_request(kind_t op, logic [KEY_W-1:0] key);
		request_t r;
		r.op = op;
		r.key = key;
		pending_requests = {pending_requests, r};
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				run_table_op(kind, owner_key);
				requests_taken <= requests_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_request = pending_requests.pop_front();
					in_valid  <= 1'b1;
					kind      <= next_request.op;
					owner_key <= next_request.key;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with one long hold-off to back up the block
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!hold_done && requests_taken >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (awaited_results.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("%0t: unexpected result found=%0b slot_id=%0d last=%0b",
						$realtime, found, slot_id, last);
				end
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (want !== {found, slot_id, last}) begin
					if (mismatch_count < 10) begin
						$display("%0t: expected found=%0b slot_id=%0d last=%0b, got found=%0b slot_id=%0d last=%0b",
							$realtime, want.found, want.slot, want.last, found, slot_id, last);
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", idle_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int roll;
		int seg;
		kind_t op;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			shadow_used[i] = 1'b0;
			shadow_key[i] = '0;
		end
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i] = {$urandom, $urandom} | 64'd1;
		end
		key_pool[0] = '1;

		// corner cases: empty table, zero keys, duplicates, extreme keys
		add_request(KIND_LIST, '0);
		add_request(KIND_ACQUIRE, '0);
		add_request(KIND_RELEASE, '0);
		add_request(KIND_LOOKUP, '0);
		add_request(KIND_ACQUIRE, '1);
		add_request(KIND_ACQUIRE, 64'd1);
		add_request(KIND_ACQUIRE, '1);
		add_request(KIND_LOOKUP, '1);
		add_request(KIND_RELEASE, '1);
		add_request(KIND_LOOKUP, '1);
		add_request(KIND_RELEASE, 64'd5);
		add_request(KIND_LOOKUP, 64'd1);
		add_request(KIND_LIST, '1);
		add_request(KIND_ACQUIRE, 64'h8000_0000_0000_0000);
		add_request(KIND_LIST, 64'h5555_aaaa_5555_aaaa);
		add_request(KIND_RELEASE, 64'd1);
		add_request(KIND_RELEASE, '1);
		add_request(KIND_RELEASE, 64'h8000_0000_0000_0000);
		add_request(KIND_LIST, '0);

		// fill, churn, drain, refill
		for (int k = 0; k < 200; k++) begin
			roll = $urandom_range(99);
			seg = k / 50;
			case (seg)
				0: op = (roll < 80) ? KIND_ACQUIRE : (roll < 88) ? KIND_LOOKUP :
					(roll < 94) ? KIND_RELEASE : KIND_LIST;
				1: op = (roll < 35) ? KIND_ACQUIRE : (roll < 60) ? KIND_LOOKUP :
					(roll < 85) ? KIND_RELEASE : KIND_LIST;
				2: op = (roll < 15) ? KIND_ACQUIRE : (roll < 35) ? KIND_LOOKUP :
					(roll < 88) ? KIND_RELEASE : KIND_LIST;
				default: op = (roll < 60) ? KIND_ACQUIRE : (roll < 75) ? KIND_LOOKUP :
					(roll < 90) ? KIND_RELEASE : KIND_LIST;
			endcase
			add_request(op, pick_key(op));
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests: %0d acquire, %0d lookup, %0d release, %0d list; %0d results checked.",
			requests_taken, op_count[KIND_ACQUIRE], op_count[KIND_LOOKUP],
			op_count[KIND_RELEASE], op_count[KIND_LIST], results_checked);
		$display("Full-table acquire rejections: %0d, longest list: %0d slots, mismatches: %0d.",
			full_rejects, longest_list, mismatch_count);
		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
